// ===== sv/slot_table_oldest_eviction_top_assert.svh =====
// assertion macros for the slot table allocator checker
// expects signals named clk and rst in the scope of use
`ifndef SLOT_TABLE_OLDEST_EVICTION_TOP_ASSERT_SVH
`define SLOT_TABLE_OLDEST_EVICTION_TOP_ASSERT_SVH

// same-cycle implication
`define STOE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STOE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/stoe_pkg.sv =====
// types and constants for the slot table allocator with oldest replacement
// no dependencies
package stoe_pkg;

  localparam int unsigned TAG_W       = 32;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned SLOT_INDEX_W = 7;

  typedef struct packed {
    logic [TAG_W-1:0]  chunk_tag;
    logic [TIME_W-1:0] load_time;
  } stoe_req_t;

  typedef struct packed {
    logic [SLOT_INDEX_W-1:0] slot_index;
    logic                    evicted;
    logic [TAG_W-1:0]        evicted_tag;
  } stoe_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } stoe_state_t;

  typedef struct packed {
    logic load_req;
    logic scan_rd;
    logic commit;
  } stoe_cmd_t;

  typedef struct packed {
    logic full;
    logic scan_end;
    logic out_free;
  } stoe_status_t;

endpackage

// ===== sv/slot_table_oldest_eviction_top.sv =====
// top level of the slot table allocator with oldest-time replacement
// depends on stoe_pkg, stoe_ctrl and stoe_dpath
//
// usage:
//   req channel (req_valid/req_ready/req) carries a chunk tag and a load time.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one result per request: the
//   slot now holding the tag, whether an occupied slot was replaced, and the
//   replaced tag (zero when none).
//   while empty slots remain an accepted request passes to the finish state,
//   which commits it into the output register that drives rsp_valid.
//   once the table is full every request scans all slot times, one memory
//   read per cycle, then passes through the drain and finish states; the
//   single read port of the slot memory makes the scan go slot by slot.
//   one request is in work at a time; req_ready is high only when idle.
//   reset empties the table (fill count to zero) and drops any pending result;
//   no clearing pass is needed.
//   a stalled receiver leaves the result in the output register; a new request
//   is still taken, and its result waits until the previous one is taken.
module slot_table_oldest_eviction_top
  import stoe_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  stoe_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output stoe_rsp_t rsp
);

  stoe_cmd_t    cmd;
  stoe_status_t status;

  stoe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  stoe_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== sv/stoe_ctrl.sv =====
// controller for the slot table allocator: accept, scan, commit sequencing
// depends on stoe_pkg
module stoe_ctrl
  import stoe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  input  stoe_status_t status,
  output stoe_cmd_t    cmd
);

  stoe_state_t state;
  stoe_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = status.full ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        if (status.scan_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready    = 1'b0;
    cmd.load_req = 1'b0;
    cmd.scan_rd  = 1'b0;
    cmd.commit   = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready    = 1'b1;
        cmd.load_req = req_valid;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      S_DRAIN: begin
      end
      S_FINISH: begin
        // hold until the output register can take the result
        cmd.commit = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/stoe_dpath.sv =====
// datapath for the slot table allocator: slot memory, fill count, oldest search
// and output register; depends on stoe_pkg
module stoe_dpath
  import stoe_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  stoe_req_t    req,
  input  stoe_cmd_t    cmd,
  output stoe_status_t status,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output stoe_rsp_t    rsp
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned WORD_W = TAG_W + TIME_W;

  // slots fill in order and never empty, so the count is the lowest free slot
  logic [CNT_W-1:0]  count;
  stoe_req_t         req_q;

  logic [WORD_W-1:0] mem [SLOT_COUNT];
  logic [WORD_W-1:0] rd_data;
  logic [IDX_W-1:0]  scan_addr;
  logic              rd_pend;
  logic [IDX_W-1:0]  rd_idx;

  logic              have_best;
  logic [IDX_W-1:0]  best_idx;
  logic [TAG_W-1:0]  best_tag;
  logic [TIME_W-1:0] best_time;

  logic              full;
  logic [IDX_W-1:0]  slot;
  logic [TAG_W-1:0]  rd_tag;
  logic [TIME_W-1:0] rd_time;

  assign full    = (count == CNT_W'(SLOT_COUNT));
  assign slot    = full ? best_idx : count[IDX_W-1:0];
  assign rd_tag  = rd_data[WORD_W-1:TIME_W];
  assign rd_time = rd_data[TIME_W-1:0];

  assign status.full     = full;
  assign status.scan_end = (scan_addr == IDX_W'(SLOT_COUNT - 1));
  assign status.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[slot] <= {req_q.chunk_tag, req_q.load_time};
    end
    if (cmd.scan_rd) begin
      rd_data <= mem[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_pend   <= 1'b0;
      have_best <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_rd;
      if (cmd.load_req) begin
        have_best <= 1'b0;
      end else if (rd_pend) begin
        have_best <= 1'b1;
      end
      if (cmd.commit && !full) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q     <= req;
      scan_addr <= '0;
    end else if (cmd.scan_rd) begin
      scan_addr <= scan_addr + IDX_W'(1);
    end
    rd_idx <= scan_addr;
    // strict less-than keeps the lowest index on equal times
    if (rd_pend && (!have_best || (rd_time < best_time))) begin
      best_idx  <= rd_idx;
      best_tag  <= rd_tag;
      best_time <= rd_time;
    end
    if (cmd.commit) begin
      rsp.slot_index  <= SLOT_INDEX_W'(slot);
      rsp.evicted     <= full;
      rsp.evicted_tag <= full ? best_tag : '0;
    end
  end

endmodule

// ===== sv/stoe_chk.sv =====
// port-level checks for the slot table allocator, bound to the top level
// depends on stoe_pkg and slot_table_oldest_eviction_top_assert.svh
`include "slot_table_oldest_eviction_top_assert.svh"

module stoe_chk
  import stoe_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input stoe_req_t req,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input stoe_rsp_t rsp
);

  logic req_fire;
  assign req_fire = req_valid && req_ready && !$isunknown(req);

  // result held while the receiver stalls
  `STOE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp dropped or changed under stall")

  // a fresh slot never reports a replaced tag
  `STOE_ASSERT_SAME(a_no_evict_tag, rsp_valid && !rsp.evicted, rsp.evicted_tag == '0, "evicted_tag set without eviction")

  // the block is busy in the cycle after it takes a request
  `STOE_ASSERT_NEXT(a_busy_after_req, req_fire, !req_ready, "request taken back to back")

  // a new result only appears when a request has been in work
  `STOE_ASSERT_SAME(a_rsp_from_work, $rose(rsp_valid), $past(!req_ready), "result without a request in work")

endmodule

bind slot_table_oldest_eviction_top stoe_chk u_chk (.*);

// ===== tb/tb_slot_table_oldest_eviction_top.sv =====
// self-checking testbench for slot_table_oldest_eviction_top: load requests are checked
// against a behavioural slot table with oldest-time replacement
// depends on stoe_pkg and slot_table_oldest_eviction_top
module tb_slot_table_oldest_eviction_top;
  import stoe_pkg::*;

  localparam int unsigned SLOT_COUNT = 128;
  localparam int CLK_HALF = 6;
  localparam int CLK_PERIOD = 2 * CLK_HALF;
  localparam int MAX_REPORTS = 10;
  localparam int LONG_HOLD = 600;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_LOADS = 375;
  localparam int TIMEOUT_CYCLES = 1200000;

  logic      clk;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  stoe_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  stoe_rsp_t rsp;

  slot_table_oldest_eviction_top #(
    .SLOT_COUNT(SLOT_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // behavioural copy of the slot table
  logic              table_valid [SLOT_COUNT];
  logic [TAG_W-1:0]  table_tag [SLOT_COUNT];
  logic [TIME_W-1:0] table_time [SLOT_COUNT];

  stoe_req_t   pending_reqs [$];
  stoe_rsp_t   expected_rsps [$];
  int          send_idle_pct = 0;
  int          rsp_stall_pct = 0;
  logic        rsp_hold = 1'b0;
  bit          hold_trigger = 1'b0;
  int          total_queued = 0;
  int          accepted_count = 0;
  int          fault_count = 0;
  int          checked_count = 0;
  int          fill_count = 0;
  int          evict_count = 0;
  int          tied_evict_count = 0;
  logic [31:0] load_clock = '0;

  function automatic stoe_rsp_t allocate_slot(stoe_req_t r);
    stoe_rsp_t res;
    int        victim;
    int        ties;
    bit        found;
    res = '0;
    victim = 0;
    ties = 0;
    found = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!found && !table_valid[i]) begin
        victim = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      // full table: smallest time wins, lowest index on a tie
      for (int i = 1; i < SLOT_COUNT; i++) begin
        if (table_time[i] < table_time[victim]) begin
          victim = i;
          ties = 0;
        end else if (table_time[i] == table_time[victim]) begin
          ties++;
        end
      end
      res.evicted = 1'b1;
      res.evicted_tag = table_tag[victim];
      evict_count++;
      if (ties != 0) tied_evict_count++;
    end else begin
      fill_count++;
    end
    res.slot_index = victim[SLOT_INDEX_W-1:0];
    table_valid[victim] = 1'b1;
    table_tag[victim] = r.chunk_tag;
    table_time[victim] = r.load_time;
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req_valid <= 1'b1;
        req <= pending_reqs.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (hold_trigger);
    @(posedge clk);
    rsp_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  // monitor: results are checked before the same-edge request is predicted
  always @(posedge clk) begin
    stoe_rsp_t exp_rsp;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("unexpected result: slot %0d evicted %0b tag %h",
                     rsp.slot_index, rsp.evicted, rsp.evicted_tag);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          checked_count++;
          if (rsp.slot_index !== exp_rsp.slot_index || rsp.evicted !== exp_rsp.evicted ||
              rsp.evicted_tag !== exp_rsp.evicted_tag) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
              $display("result %0d mismatch: exp slot %0d evicted %0b tag %h, got slot %0d evicted %0b tag %h",
                       checked_count, exp_rsp.slot_index, exp_rsp.evicted,
                       exp_rsp.evicted_tag, rsp.slot_index, rsp.evicted, rsp.evicted_tag);
          end
        end
      end
      if (req_valid && req_ready) begin
        expected_rsps.push_back(allocate_slot(req));
        accepted_count++;
      end
    end
  end

  task automatic queue_load(input logic [TAG_W-1:0] tag, input logic [TIME_W-1:0] t);
    stoe_req_t r;
    r.chunk_tag = tag;
    r.load_time = t;
    pending_reqs.push_back(r);
    total_queued++;
  endtask

  // mostly rising load times as a real loader would give, with repeats,
  // stray values and tiny or maximal times mixed in
  task automatic queue_random_loads(input int n);
    int                mode;
    int                tag_mode;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] t;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(0, 99);
      tag_mode = $urandom_range(0, 99);
      if (mode < 60) load_clock += $urandom_range(1, 100);
      else if (mode < 70) load_clock += $urandom_range(0, 32'h00FF_FFFF);
      if (mode < 82) t = load_clock;
      else if (mode < 90) t = $urandom;
      else if (mode < 98) t = $urandom_range(0, 3);
      else t = '1;
      if (tag_mode < 3) tag = '0;
      else if (tag_mode < 6) tag = '1;
      else tag = $urandom;
      queue_load(tag, t);
    end
  endtask

  task automatic drain_all();
    while (accepted_count != total_queued || expected_rsps.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int s_idle, input int r_stall, input bit with_hold,
                           input logic [31:0] start_clock);
    send_idle_pct = s_idle;
    rsp_stall_pct = r_stall;
    load_clock = start_clock;
    queue_random_loads(PHASE_LOADS);
    if (with_hold) hold_trigger = 1'b1;
    drain_all();
  endtask

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      table_valid[i] = 1'b0;
      table_tag[i] = '0;
      table_time[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes, several zero times so the first evictions tie,
    // a zero tag evicted first, and a maximal time that outlives the rest
    queue_load('0, '0);
    queue_load('1, '1);
    queue_load(32'h0000_0001, 32'h0000_0001);
    queue_load(32'h8000_0000, '0);
    queue_load(32'h7FFF_FFFF, 32'h8000_0000);
    queue_load(32'h5555_5555, 32'h7FFF_FFFF);
    queue_load(32'hAAAA_AAAA, '0);
    queue_load(32'h1234_5678, 32'h0000_0010);
    queue_load(32'hFFFF_0000, 32'h0000_0010);
    queue_load(32'h0000_FFFF, 32'hFFFF_FFFE);
    for (int k = 0; k < 15; k++) queue_load($urandom, 32'h0000_0100 + k);
    drain_all();

    run_phase(0, 0, 1'b1, 32'h0000_1000);
    run_phase(67, 0, 1'b0, 32'h0100_0000);
    run_phase(0, 67, 1'b0, 32'h4000_0000);
    // start just short of the top so the load times wrap and count as oldest
    run_phase(37, 37, 1'b0, 32'hFFFF_F000);
    run_phase(0, 0, 1'b0, 32'h8000_0000);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_rsps.size() != 0) begin
      fault_count++;
      $display("%0d expected results never arrived", expected_rsps.size());
    end

    $display("checked %0d results: %0d into empty slots, %0d evictions (%0d with tied times)",
             checked_count, fill_count, evict_count, tied_evict_count);
    $display("phases: no idling with a long receiver hold, sender gaps, receiver stalls, both");
    if (fault_count == 0) begin
      $display("tb_slot_table_oldest_eviction_top: PASS");
    end else begin
      $display("%0d failures", fault_count);
      $display("tb_slot_table_oldest_eviction_top: FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout after %0d cycles", TIMEOUT_CYCLES);
    $display("tb_slot_table_oldest_eviction_top: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/stoe_pkg.sv
sv/stoe_ctrl.sv
sv/stoe_dpath.sv
sv/slot_table_oldest_eviction_top.sv
sv/stoe_chk.sv
tb/tb_slot_table_oldest_eviction_top.sv
